@@ hdl/endpoint_parse_register_lookup_defines.svh @@
// Assertion macros used by the endpoint parser table engine.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef ENDPOINT_PARSE_REGISTER_LOOKUP_DEFINES_SVH
`define ENDPOINT_PARSE_REGISTER_LOOKUP_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define EPR_ASSERT_NOW(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define EPR_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/epr_pkg.sv @@
// Types and constants for the endpoint parser and lookup table.
// No dependencies.
package epr_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int LINE_BITS_DEF   = 16;
   localparam int KEY_BITS        = 48;
   localparam int VALUE_BITS      = 17;
   localparam logic [VALUE_BITS-1:0] VALUE_CAP = 17'h1FFFF;
   localparam logic [VALUE_BITS-1:0] OCTET_MAX = 17'd255;
   localparam logic [VALUE_BITS-1:0] PORT_MAX  = 17'd65535;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [2:0] FIELD_PORT = 3'd3;
   localparam logic [2:0] FIELD_DONE = 3'd4;
   localparam logic [2:0] DIGITS_CAP = 3'd7;

   localparam logic CMD_REGISTER = 1'b0;
   localparam logic CMD_QUERY    = 1'b1;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_FAIL  = 3'd1;
   localparam logic [2:0] ST_ERR   = 3'd2;
   localparam logic [2:0] ST_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL  = 3'd4;

   typedef struct packed {
      logic       cmd;
      logic [7:0] ch;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] server_line;
   } rsp_type;

   typedef struct packed {
      logic                cmd;
      logic                valid;
      logic [KEY_BITS-1:0] key;
   } line_info_type;

endpackage

@@ hdl/epr_front.sv @@
// Character parser: builds the endpoint key and checks syntax per line.
// Depends on epr_pkg.
module epr_front import epr_pkg::*; #(
   parameter int LINE_BITS = LINE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 push,
   input  logic                 queue_full,
   output line_info_type        push_info,
   output logic [LINE_BITS-1:0] push_line
);

   logic [2:0]            idx_ff, idx_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [2:0]            dig_ff, dig_in;
   logic                  fz_ff, fz_in;
   logic                  bad_ff, bad_in;
   logic [KEY_BITS-1:0]   kb_ff, kb_in;
   logic [LINE_BITS-1:0]  line_ff, line_in;
   logic [20:0]           prod;
   logic                  take;

   function automatic logic field_ok(input logic [2:0] d, input logic z,
                                     input logic [VALUE_BITS-1:0] v,
                                     input logic [VALUE_BITS-1:0] lim);
      return (d != 3'd0) && !((d > 3'd1) && z) && (v <= lim);
   endfunction

   assign req_ready = !queue_full;
   assign take = req_valid && req_ready;

   always_comb begin
      idx_in  = idx_ff;
      val_in  = val_ff;
      dig_in  = dig_ff;
      fz_in   = fz_ff;
      bad_in  = bad_ff;
      kb_in   = kb_ff;
      line_in = line_ff;
      push    = 1'b0;
      push_info = '0;
      push_line = line_ff + 1'b1;
      prod = ({4'b0, val_ff} << 3) + ({4'b0, val_ff} << 1)
             + {13'b0, req_data.ch - CH_ZERO};
      if (req_data.ch inside {[CH_ZERO:CH_NINE]}) begin
         if (dig_ff == 3'd0) fz_in = (req_data.ch == CH_ZERO);
         if (dig_ff < DIGITS_CAP) dig_in = dig_ff + 3'd1;
         val_in = (prod > {4'b0, VALUE_CAP}) ? VALUE_CAP : prod[VALUE_BITS-1:0];
      end else if ((req_data.ch == CH_DOT && idx_ff < FIELD_PORT) ||
                   (req_data.ch == CH_COLON && idx_ff == FIELD_PORT)) begin
         if (!field_ok(dig_ff, fz_ff, val_ff, OCTET_MAX)) bad_in = 1'b1;
         kb_in  = {kb_ff[KEY_BITS-9:0], val_ff[7:0]};
         idx_in = idx_ff + 3'd1;
         val_in = '0;
         dig_in = '0;
         fz_in  = 1'b0;
      end else begin
         bad_in = 1'b1;
      end
      if (req_data.line_end) begin
         push = take;
         push_info.cmd   = req_data.cmd;
         push_info.valid = !bad_in && (idx_in == FIELD_DONE)
                           && field_ok(dig_in, fz_in, val_in, PORT_MAX);
         push_info.key   = {kb_in[31:0], val_in[15:0]};
         line_in = line_ff + 1'b1;
         idx_in  = '0;
         val_in  = '0;
         dig_in  = '0;
         fz_in   = 1'b0;
         bad_in  = 1'b0;
         kb_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         val_ff  <= '0;
         dig_ff  <= '0;
         fz_ff   <= 1'b0;
         bad_ff  <= 1'b0;
         kb_ff   <= '0;
         line_ff <= '0;
      end else if (take) begin
         idx_ff  <= idx_in;
         val_ff  <= val_in;
         dig_ff  <= dig_in;
         fz_ff   <= fz_in;
         bad_ff  <= bad_in;
         kb_ff   <= kb_in;
         line_ff <= line_in;
      end
   end

endmodule

@@ hdl/epr_queue.sv @@
// Two-entry queue between the parser and the table engine.
// Depends on epr_pkg.
module epr_queue import epr_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

@@ hdl/epr_back.sv @@
// Table engine: sequential key search, insert, and result register.
// Depends on epr_pkg and the assertion macro header.
`include "endpoint_parse_register_lookup_defines.svh"
module epr_back import epr_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int LINE_BITS   = LINE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  line_info_type        q_info,
   input  logic [LINE_BITS-1:0] q_line,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data
);

   localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(TABLE_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_CMP  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [KEY_BITS-1:0]  keys_mem  [TABLE_DEPTH];
   logic [LINE_BITS-1:0] lines_mem [TABLE_DEPTH];
   logic [KEY_BITS-1:0]  rd_key_ff;
   logic [LINE_BITS-1:0] rd_line_ff;
   logic [CNT_BITS-1:0]  cnt_ff, idx_ff, idx_in;
   line_info_type        info_ff, info_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   rsp_type              res_ff, res_in, out_ff;
   logic                 out_valid_ff;
   logic                 decide, hit, wr_en;
   logic [LINE_BITS-1:0] hit_line;
   logic [31:0]          hit_wide;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      info_in  = info_ff;
      line_in  = line_ff;
      res_in   = res_ff;
      q_pop    = 1'b0;
      decide   = 1'b0;
      hit      = 1'b0;
      hit_line = rd_line_ff;
      wr_en    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               info_in = q_info;
               line_in = q_line;
               idx_in  = '0;
               if (!q_info.valid) begin
                  res_in   = '{status: ST_ERR, server_line: 16'd0};
                  state_in = S_DONE;
               end else if (cnt_ff == '0) begin
                  decide = 1'b1;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: state_in = S_CMP;
         S_CMP: begin
            if (rd_key_ff == info_ff.key) begin
               hit    = 1'b1;
               decide = 1'b1;
            end else if (idx_ff + 1'b1 == cnt_ff) begin
               decide = 1'b1;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      hit_wide = 32'(hit_line);
      if (decide) begin
         state_in = S_DONE;
         if (info_in.cmd == CMD_QUERY) begin
            res_in = hit ? rsp_type'{status: ST_FOUND, server_line: hit_wide[15:0]}
                         : rsp_type'{status: ST_FAIL, server_line: 16'd0};
         end else if (hit) begin
            res_in = '{status: ST_FAIL, server_line: 16'd0};
         end else if (cnt_ff >= DEPTH_CNT) begin
            res_in = '{status: ST_FULL, server_line: 16'd0};
         end else begin
            res_in = '{status: ST_OK, server_line: 16'd0};
            wr_en  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         keys_mem[cnt_ff[IDX_BITS-1:0]]  <= info_in.key;
         lines_mem[cnt_ff[IDX_BITS-1:0]] <= line_in;
      end
      rd_key_ff  <= keys_mem[idx_ff[IDX_BITS-1:0]];
      rd_line_ff <= lines_mem[idx_ff[IDX_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      info_ff <= info_in;
      line_ff <= line_in;
      res_ff  <= res_in;
      idx_ff  <= idx_in;
      if (state_ff == S_DONE && state_in == S_IDLE) out_ff <= res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (wr_en) cnt_ff <= cnt_ff + 1'b1;
         if (state_ff == S_DONE && state_in == S_IDLE) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `EPR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ff <= DEPTH_CNT, "entry count above depth")
   `EPR_ASSERT_NEXT(a_cnt_step, wr_en, cnt_ff == $past(cnt_ff) + 1'b1, "insert lost")
   `EPR_ASSERT_NOW(a_pop_idle, q_pop, state_ff == S_IDLE, "queue pop while busy")
   `EPR_ASSERT_NOW(a_idx_range, state_ff == S_CMP, idx_ff < cnt_ff, "search past count")

endmodule

@@ hdl/endpoint_parse_register_lookup.sv @@
// Top level of the endpoint parser with register/lookup table.
// Depends on epr_pkg, epr_front, epr_queue and epr_back.
//
// Characters of a.b.c.d:e lines enter at one per cycle while the two-line queue has room;
// each line end gives one result. The table engine handles one line at a time through the
// single read port of the key table: an invalid line goes straight to the result; a valid line
// reads and compares stored entries one by one (up to entry count), then hands off its result.
module endpoint_parse_register_lookup import epr_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int LINE_BITS   = LINE_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int QW = $bits(line_info_type) + LINE_BITS;

   logic                 push, full, pop, not_empty;
   line_info_type        push_info, pop_info;
   logic [LINE_BITS-1:0] push_line, pop_line;
   logic [QW-1:0]        pop_data;

   epr_front #(.LINE_BITS(LINE_BITS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .push, .queue_full(full), .push_info, .push_line
   );

   epr_queue #(.WIDTH(QW)) u_queue (
      .clock, .reset, .push, .push_data({push_info, push_line}), .full,
      .pop, .not_empty, .pop_data
   );

   assign pop_info = pop_data[QW-1:LINE_BITS];
   assign pop_line = pop_data[LINE_BITS-1:0];

   epr_back #(.TABLE_DEPTH(TABLE_DEPTH), .LINE_BITS(LINE_BITS)) u_back (
      .clock, .reset, .q_valid(not_empty), .q_pop(pop), .q_info(pop_info),
      .q_line(pop_line), .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule
